// ===== rtl/wspdl_pkg.sv =====
// ----------------------------------------------------------------------------
// wspdl_pkg
// Shared types and constants of the wheel speed PI duty limiter.
// ----------------------------------------------------------------------------
package wspdl_pkg;

  localparam int unsigned ZERO_DUTY_LEVEL_DEF = 16;
  localparam int unsigned STOP_SPEED_DEF      = 64;
  localparam int unsigned MIN_STEP_MS_DEF     = 5;

  localparam int unsigned MUL_A_W   = 48;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_DIG_W = 5;

  // radix-4 digits per product
  localparam logic [MUL_DIG_W-1:0] GAIN_DIGITS = 5'd12;
  localparam logic [MUL_DIG_W-1:0] TIME_DIGITS = 5'd16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP            = 3'd0,
    REG_KI            = 3'd1,
    REG_KW            = 3'd2,
    REG_DUTY_LIMIT    = 3'd3,
    REG_MOVE_FLOOR    = 3'd4,
    REG_START_FLOOR   = 3'd5,
    REG_INVERT_SPEED  = 3'd6,
    REG_BRAKE_SPEED   = 3'd7
  } reg_idx_t;

  localparam logic [23:0] KP_RESET           = 24'd65536;
  localparam logic [23:0] KI_RESET           = 24'd655;
  localparam logic [23:0] KW_RESET           = 24'd65536;
  localparam logic [14:0] DUTY_LIMIT_RESET   = 15'd16384;
  localparam logic [14:0] MOVE_FLOOR_RESET   = 15'd3277;
  localparam logic [14:0] START_FLOOR_RESET  = 15'd4915;
  localparam logic [14:0] INVERT_SPEED_RESET = 15'd256;
  localparam logic [14:0] BRAKE_SPEED_RESET  = 15'd2560;

  typedef struct packed {
    logic                 start;
    logic [MUL_DIG_W-1:0] digits;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_P,
    ST_MUL_I,
    ST_RAW,
    ST_LIMIT,
    ST_ANTI_GO,
    ST_MUL_A,
    ST_INC_GO,
    ST_MUL_D,
    ST_INTEG,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/wheel_speed_pi_duty_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_pi_duty_limiter_unit
// Per-wheel PI speed loop with back-calculation anti-windup and duty limiter.
// Restarts and too-short intervals skip the multiplier. One item at a time:
// the next item is taken only after the previous result is loaded, later
// while a result waits. A control update uses four products on one radix-4
// serial multiplier (12 + 12 + 12 + 16 digits) plus the sequencer steps.
// Synchronous reset clears the integrator, last duty and last time, and
// sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module wheel_speed_pi_duty_limiter_unit #(
  parameter int unsigned ZERO_DUTY_LEVEL = wspdl_pkg::ZERO_DUTY_LEVEL_DEF,
  parameter int unsigned STOP_SPEED      = wspdl_pkg::STOP_SPEED_DEF,
  parameter int unsigned MIN_STEP_MS     = wspdl_pkg::MIN_STEP_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wspdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wspdl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,  // now_ms, speed_ref, speed_measured
  input  logic                            s_tuser,  // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata   // duty, duty_magnitude, forward, brake
);
  import wspdl_pkg::*;

  logic [23:0] kp, ki, kw;
  logic [14:0] duty_limit, move_floor, start_floor, invert_speed, brake_speed;

  logic               in_func;
  logic [31:0]        in_now;
  logic signed [15:0] in_ref, in_meas;

  logic signed [47:0] integ;
  logic signed [15:0] prev_duty;
  logic [31:0]        prev_time;

  logic [31:0]        dt;
  logic [29:0]        p1;
  logic signed [31:0] raw;
  logic [31:0]        diff_mag;
  logic               diff_neg;
  logic [36:0]        x_mag;
  logic               x_neg;
  logic [48:0]        inc;

  logic signed [15:0] res_val;
  logic [14:0]        res_abs;
  logic               res_fwd, res_brk;

  state_t    state, state_next;
  mul_ctl_t  mul_ctl;
  mul_stat_t mul_stat;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               out_load;

  wspdl_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .stat (mul_stat),
    .prod (mul_prod)
  );

  // shared combinational terms
  logic signed [16:0] err;
  logic [15:0]        err_mag;
  logic [31:0]        dt_c;
  logic [47:0]        int_mag;
  logic [15:0]        prev_mag;
  logic signed [63:0] raw_sum;
  logic signed [31:0] raw_sat;
  logic [31:0]        raw_mag;
  logic               fwd_c;
  logic [15:0]        wm_mag;
  logic [31:0]        lim_a, lim_b, lim_c;
  logic               refuse, brk_c;
  logic signed [15:0] val_c;
  logic signed [33:0] diff_c;
  logic [35:0]        anti;
  logic signed [37:0] x_c;
  logic signed [49:0] ni;

  always_comb begin
    err      = {in_ref[15], in_ref} - {in_meas[15], in_meas};
    err_mag  = err[16] ? 16'(-err) : err[15:0];
    dt_c     = in_now - prev_time;
    int_mag  = integ[47] ? 48'(-integ) : 48'(integ);
    prev_mag = prev_duty[15] ? 16'(-prev_duty) : 16'(prev_duty);

    raw_sum = (err[16] ? -$signed({34'd0, p1}) : $signed({34'd0, p1}))
            + (integ[47] ? -$signed({2'b00, mul_prod[79:18]})
                         : $signed({2'b00, mul_prod[79:18]}));
    if (raw_sum > 64'sh7FFF_FFFF)       raw_sat = 32'sh7FFF_FFFF;
    else if (raw_sum < -64'sh8000_0000) raw_sat = 32'sh8000_0000;
    else                                raw_sat = raw_sum[31:0];

    fwd_c   = !raw[31];
    raw_mag = raw[31] ? 32'(-raw) : 32'(raw);
    wm_mag  = in_meas[15] ? 16'(-in_meas) : 16'(in_meas);
    if (raw_mag >= {17'd0, move_floor})
      lim_a = (raw_mag > {17'd0, duty_limit}) ? {17'd0, duty_limit} : raw_mag;
    else if (raw_mag > 32'(ZERO_DUTY_LEVEL))
      lim_a = {17'd0, move_floor};
    else
      lim_a = '0;
    refuse = (fwd_c == in_meas[15]) && ({1'b0, wm_mag} > {2'b00, invert_speed});
    brk_c  = refuse && ({1'b0, wm_mag} < {2'b00, brake_speed});
    lim_b  = refuse ? '0 : lim_a;
    if (lim_b > 32'(ZERO_DUTY_LEVEL) && {16'd0, wm_mag} < 32'(STOP_SPEED))
      lim_c = (lim_b < {17'd0, start_floor}) ? {17'd0, start_floor} : lim_b;
    else
      lim_c = lim_b;
    val_c  = fwd_c ? $signed({1'b0, lim_c[14:0]}) : -$signed({1'b0, lim_c[14:0]});
    diff_c = {raw[31], raw[31], raw} - {{18{val_c[15]}}, val_c};

    anti = mul_prod[65:30];
    x_c  = {{21{err[16]}}, err}
         - (diff_neg ? -$signed({2'b00, anti}) : $signed({2'b00, anti}));

    ni = x_neg ? {integ[47], integ[47], integ} - $signed({1'b0, inc})
               : {integ[47], integ[47], integ} + $signed({1'b0, inc});
  end

  // sequencer
  always_comb begin
    state_next     = state;
    mul_ctl.start  = 1'b0;
    mul_ctl.digits = GAIN_DIGITS;
    mul_a          = {32'd0, err_mag};
    mul_b          = {8'd0, kp};
    s_tready       = 1'b0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (in_func || dt_c < 32'(MIN_STEP_MS)) begin
          state_next = ST_DONE;
        end else begin
          mul_ctl.start = 1'b1;
          state_next    = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        mul_a = int_mag;
        mul_b = {8'd0, ki};
        if (mul_stat.done) begin
          mul_ctl.start = 1'b1;
          state_next    = ST_MUL_I;
        end
      end
      ST_MUL_I: if (mul_stat.done) state_next = ST_RAW;
      ST_RAW:   state_next = ST_LIMIT;
      ST_LIMIT: state_next = ST_ANTI_GO;
      ST_ANTI_GO: begin
        mul_a         = {16'd0, diff_mag};
        mul_b         = {8'd0, kw};
        mul_ctl.start = 1'b1;
        state_next    = ST_MUL_A;
      end
      ST_MUL_A: if (mul_stat.done) state_next = ST_INC_GO;
      ST_INC_GO: begin
        mul_a          = {11'd0, x_mag};
        mul_b          = dt;
        mul_ctl.digits = TIME_DIGITS;
        mul_ctl.start  = 1'b1;
        state_next     = ST_MUL_D;
      end
      ST_MUL_D: if (mul_stat.done) state_next = ST_INTEG;
      ST_INTEG: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp           <= KP_RESET;
      ki           <= KI_RESET;
      kw           <= KW_RESET;
      duty_limit   <= DUTY_LIMIT_RESET;
      move_floor   <= MOVE_FLOOR_RESET;
      start_floor  <= START_FLOOR_RESET;
      invert_speed <= INVERT_SPEED_RESET;
      brake_speed  <= BRAKE_SPEED_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_KP:           kp           <= cfg_data;
        REG_KI:           ki           <= cfg_data;
        REG_KW:           kw           <= cfg_data;
        REG_DUTY_LIMIT:   duty_limit   <= cfg_data[14:0];
        REG_MOVE_FLOOR:   move_floor   <= cfg_data[14:0];
        REG_START_FLOOR:  start_floor  <= cfg_data[14:0];
        REG_INVERT_SPEED: invert_speed <= cfg_data[14:0];
        REG_BRAKE_SPEED:  brake_speed  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      prev_duty <= '0;
      prev_time <= '0;
    end else if (state == ST_CHECK && in_func) begin
      integ     <= '0;
      prev_duty <= '0;
      prev_time <= in_now;
    end else if (state == ST_INTEG) begin
      if (ni > 50'sh7FFF_FFFF_FFFF)       integ <= 48'sh7FFF_FFFF_FFFF;
      else if (ni < -50'sh8000_0000_0000) integ <= 48'sh8000_0000_0000;
      else                                integ <= ni[47:0];
      prev_duty <= res_val;
      prev_time <= in_now;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_func <= s_tuser;
          in_now  <= s_tdata[31:0];
          in_ref  <= s_tdata[47:32];
          in_meas <= s_tdata[63:48];
        end
      end
      ST_CHECK: begin
        dt      <= dt_c;
        res_brk <= 1'b0;
        if (in_func) begin
          res_val <= '0;
          res_abs <= '0;
          res_fwd <= 1'b1;
        end else begin
          res_val <= prev_duty;
          res_abs <= prev_mag[14:0];
          res_fwd <= !prev_duty[15];
        end
      end
      ST_MUL_P: if (mul_stat.done) p1 <= mul_prod[47:18];
      ST_RAW:   raw <= raw_sat;
      ST_LIMIT: begin
        res_val  <= val_c;
        res_abs  <= lim_c[14:0];
        res_fwd  <= fwd_c;
        res_brk  <= brk_c;
        diff_neg <= diff_c[33];
        diff_mag <= diff_c[33] ? 32'(-diff_c) : diff_c[31:0];
      end
      ST_MUL_A: begin
        if (mul_stat.done) begin
          x_neg <= x_c[37];
          x_mag <= x_c[37] ? 37'(-x_c) : x_c[36:0];
        end
      end
      ST_MUL_D: begin
        if (mul_stat.done)
          inc <= (mul_prod > {31'd0, 1'b1, 48'd0}) ? {1'b1, 48'd0} : mul_prod[48:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {7'd0, res_brk, res_fwd, res_abs, res_val};
  end

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_MUL_P || state == ST_MUL_I ||
                       state == ST_MUL_A || state == ST_MUL_D))
    else $error("multiplier finished outside a wait state");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CHECK)
    else $error("accepted item not checked next");

  a_reverse_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[31] |-> (m_tdata[15] || m_tdata[15:0] == 16'd0))
    else $error("reverse item with positive duty");

  a_ready_mul_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !mul_stat.busy)
    else $error("input ready while multiplier busy");

endmodule

// ===== rtl/wspdl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// wspdl_serial_mul
// Unsigned radix-4 digit-serial multiplier. The multiplier operand shifts out
// two bits per cycle while busy; the partial sum shifts right into lo.
// After n digits the product sits at {hi, lo} >> (MUL_B_W - 2n).
// ----------------------------------------------------------------------------
module wspdl_serial_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  wspdl_pkg::mul_ctl_t          ctl,
  input  logic [wspdl_pkg::MUL_A_W-1:0] a,
  input  logic [wspdl_pkg::MUL_B_W-1:0] b,
  output wspdl_pkg::mul_stat_t         stat,
  output logic [wspdl_pkg::MUL_P_W-1:0] prod
);
  import wspdl_pkg::*;

  logic [MUL_A_W-1:0]   a1;
  logic [MUL_A_W+1:0]   a3;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_B_W-1:0]   bsh;
  logic [MUL_DIG_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W+1:0]   addend;
  logic [MUL_A_W+1:0]   sum;

  always_comb begin
    case (bsh[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a1};
      2'd2:    addend = {1'b0, a1, 1'b0};
      default: addend = a3;
    endcase
    sum = {2'b00, hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.digits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_DIG_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a1  <= a;
      a3  <= {2'b00, a} + {1'b0, a, 1'b0};
      hi  <= '0;
      lo  <= '0;
      bsh <= b;
    end else if (busy) begin
      hi  <= sum[MUL_A_W+1:2];
      lo  <= {sum[1:0], lo[MUL_B_W-1:2]};
      bsh <= {2'b00, bsh[MUL_B_W-1:2]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = {hi, lo};

endmodule

// ===== test/wspdl_checker.sv =====
// ----------------------------------------------------------------------------
// wspdl_checker
// Watches the input and result streams of the wheel speed PI duty limiter,
// computes the expected duty, magnitude, direction and brake flag of every
// accepted item and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module wspdl_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import wspdl_pkg::*;

  localparam longint I48_MAX = 64'sh7FFFFFFFFFFF;
  localparam longint I48_MIN = -I48_MAX - 1;
  localparam longint INC_LIM = 64'sh1000000000000;

  logic [23:0] kp, ki, kw;
  logic [14:0] duty_limit, min_move, min_start, inv_speed, brk_speed;
  longint      integ;
  int          last_duty;
  logic [31:0] last_time;
  logic [39:0] duty_queue[$];

  function automatic longint magn(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint scaled(longint a, longint k, int sh);
    logic [127:0] p;
    p = (128'(magn(a)) * 128'(k)) >> sh;
    return a < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [39:0] pack_duty(int d, logic fwd, logic brk);
    logic [15:0] dv;
    logic [14:0] mv;
    dv = d[15:0];
    mv = 15'(magn(d));
    return {7'd0, brk, fwd, mv, dv};
  endfunction

  task automatic predict_item(logic func, logic [31:0] now, logic signed [15:0] sref,
                              logic signed [15:0] smeas);
    logic [31:0] dt;
    longint err, raw, val, absd, awm, anti, x, m, inc, ni, dir;
    logic fwd, brk;
    if (func) begin
      integ = 0;
      last_duty = 0;
      last_time = now;
      duty_queue.push_back(pack_duty(0, 1'b1, 1'b0));
      return;
    end
    dt = now - last_time;
    if (dt < MIN_STEP_MS_DEF) begin
      duty_queue.push_back(pack_duty(last_duty, last_duty >= 0, 1'b0));
      return;
    end
    err = longint'(sref) - longint'(smeas);
    raw = scaled(err, kp, 10) + scaled(integ, ki, 10);
    if (raw > 64'sd2147483647) raw = 64'sd2147483647;
    if (raw < -64'sd2147483648) raw = -64'sd2147483648;
    fwd = raw >= 0;
    dir = fwd ? 1 : -1;
    absd = magn(raw);
    val = raw;
    if (absd >= min_move) begin
      if (absd > duty_limit) begin
        absd = duty_limit;
        val = longint'(duty_limit) * dir;
      end
    end else if (absd > ZERO_DUTY_LEVEL_DEF) begin
      absd = min_move;
      val = longint'(min_move) * dir;
    end else begin
      absd = 0;
      val = 0;
    end
    awm = magn(longint'(smeas));
    brk = 1'b0;
    if (fwd != (smeas >= 0) && awm > inv_speed) begin
      absd = 0;
      val = 0;
      brk = awm < brk_speed;
    end
    if (absd > ZERO_DUTY_LEVEL_DEF && awm < STOP_SPEED_DEF) begin
      if (absd < min_start) absd = min_start;
      val = absd * dir;
    end
    anti = scaled(raw - val, kw, 22);
    x = err - anti;
    m = magn(x);
    if (m > INC_LIM / longint'(dt)) inc = INC_LIM;
    else inc = m * longint'(dt);
    if (inc > INC_LIM) inc = INC_LIM;
    ni = x < 0 ? integ - inc : integ + inc;
    if (ni > I48_MAX) ni = I48_MAX;
    if (ni < I48_MIN) ni = I48_MIN;
    integ = ni;
    last_time = now;
    last_duty = int'(val);
    duty_queue.push_back(pack_duty(int'(val), fwd, brk));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kp <= KP_RESET; ki <= KI_RESET; kw <= KW_RESET;
      duty_limit <= DUTY_LIMIT_RESET; min_move <= MOVE_FLOOR_RESET;
      min_start <= START_FLOOR_RESET; inv_speed <= INVERT_SPEED_RESET;
      brk_speed <= BRAKE_SPEED_RESET;
      integ = 0; last_duty = 0; last_time = 0;
      duty_queue.delete();
      errors <= 0;
      pending <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_KP:           kp <= cfg_data;
          REG_KI:           ki <= cfg_data;
          REG_KW:           kw <= cfg_data;
          REG_DUTY_LIMIT:   duty_limit <= cfg_data[14:0];
          REG_MOVE_FLOOR:   min_move <= cfg_data[14:0];
          REG_START_FLOOR:  min_start <= cfg_data[14:0];
          REG_INVERT_SPEED: inv_speed <= cfg_data[14:0];
          REG_BRAKE_SPEED:  brk_speed <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (duty_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", m_tdata);
          errors <= errors + 1;
        end else begin
          logic [39:0] want;
          want = duty_queue.pop_front();
          if (want != m_tdata) begin
            if (errors < 10)
              $display("mismatch: duty %0d/%0d mag %0d/%0d fwd %b/%b brake %b/%b",
                       $signed(want[15:0]), $signed(m_tdata[15:0]), want[30:16],
                       m_tdata[30:16], want[31], m_tdata[31], want[32], m_tdata[32]);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_item(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[63:48]);
      pending <= duty_queue.size();
    end
  end
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives updates and restarts into the wheel speed PI duty limiter across
// several gain and limit settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
  import wspdl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          errors, pending, results_seen;
  bit          calm = 1'b0;
  logic [31:0] clock_ms = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wheel_speed_pi_duty_limiter_unit dut (.*);

  wspdl_checker chk (.*);

  always @(posedge clk)
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);

  // valid stays up after the handshake until the next item or a wait
  task automatic send_item(logic func, logic [31:0] now, logic [15:0] sref, logic [15:0] smeas);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {smeas, sref, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_empty;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain;
    wait_empty();
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic random_update;
    logic [31:0] step;
    logic [15:0] sref, smeas;
    case ($urandom_range(9))
      0: step = $urandom_range(4);
      1: step = $urandom;
      2: step = $urandom_range(100000);
      default: step = $urandom_range(5, 40);
    endcase
    clock_ms = clock_ms + step;
    case ($urandom_range(4))
      0: begin sref = 16'($urandom); smeas = 16'($urandom); end
      1: begin sref = 16'($urandom_range(0, 8191)); smeas = 16'($urandom_range(0, 200) - 100); end
      2: begin smeas = 16'($urandom); sref = smeas + 16'($urandom_range(0, 64) - 32); end
      default: begin
        sref = 16'($urandom_range(0, 6000) - 3000); smeas = 16'($urandom_range(0, 6000) - 3000);
      end
    endcase
    send_item($urandom_range(24) == 0, clock_ms, sref, smeas);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, restart, short interval, reversal, start boost
    send_item(1'b0, 32'd3, 16'h7FFF, 16'h8000);
    send_item(1'b0, 32'd10, 16'h7FFF, 16'h8000);
    send_item(1'b0, 32'd12, 16'h0000, 16'h0000);
    send_item(1'b0, 32'd20, 16'h8000, 16'h7FFF);
    send_item(1'b0, 32'd30, 16'h0010, 16'h0000);
    send_item(1'b0, 32'd40, 16'h0000, 16'h0000);
    send_item(1'b1, 32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 32'd5, 16'hFC00, 16'h0400);
    send_item(1'b0, 32'd20, 16'hFC00, 16'h0100);
    send_item(1'b0, 32'd40, 16'h0200, 16'h0020);
    send_item(1'b0, 32'd40, 16'h0200, 16'h0020);
    send_item(1'b0, 32'hFFFF_FFFF, 16'h0001, 16'h0000);
    send_item(1'b1, 32'd0, 16'h0000, 16'h0000);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_KP, 24'hFFFFFF); write_reg(REG_KI, 24'hFFFFFF);
          write_reg(REG_KW, 24'hFFFFFF); write_reg(REG_DUTY_LIMIT, 24'd16384);
          write_reg(REG_MOVE_FLOOR, 24'd0); write_reg(REG_START_FLOOR, 24'd16384);
          write_reg(REG_INVERT_SPEED, 24'd0); write_reg(REG_BRAKE_SPEED, 24'd32767);
        end
        1: begin
          write_reg(REG_KP, 24'd0); write_reg(REG_KI, 24'd0); write_reg(REG_KW, 24'd0);
          write_reg(REG_DUTY_LIMIT, 24'd0); write_reg(REG_MOVE_FLOOR, 24'd16384);
          write_reg(REG_START_FLOOR, 24'd0); write_reg(REG_INVERT_SPEED, 24'd32767);
          write_reg(REG_BRAKE_SPEED, 24'd0);
        end
        2: begin
          write_reg(REG_KP, 24'd65536); write_reg(REG_KI, 24'd655);
          write_reg(REG_KW, 24'd65536); write_reg(REG_DUTY_LIMIT, 24'd2000);
          write_reg(REG_MOVE_FLOOR, 24'd3000); write_reg(REG_START_FLOOR, 24'd8000);
          write_reg(REG_INVERT_SPEED, 24'd256); write_reg(REG_BRAKE_SPEED, 24'd2560);
        end
        default: begin
          write_reg(REG_KP, 24'($urandom)); write_reg(REG_KI, 24'($urandom_range(4000)));
          write_reg(REG_KW, 24'($urandom));
          write_reg(REG_DUTY_LIMIT, 24'($urandom_range(16384)));
          write_reg(REG_MOVE_FLOOR, 24'($urandom_range(16384)));
          write_reg(REG_START_FLOOR, 24'($urandom_range(16384)));
          write_reg(REG_INVERT_SPEED, 24'($urandom_range(32767)));
          write_reg(REG_BRAKE_SPEED, 24'($urandom_range(32767)));
        end
      endcase
      cfg_we <= 1'b0;
      calm = (phase == 4);
      for (int n = 0; n < 85; n++) begin
        random_update();
        if (n == 40) wait_empty();
      end
      drain();
    end
    calm = 1'b0;
    $display("covered %0d results over six register settings, restarts and short intervals",
             results_seen);
    if (errors == 0) $display("PASS wheel_speed_pi_duty_limiter_unit");
    else $display("FAIL wheel_speed_pi_duty_limiter_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL wheel_speed_pi_duty_limiter_unit");
    $finish;
  end
endmodule
